[rtl/core/multichannel_phase_dimmer_assert.svh]
// ----------------------------------------------------------------------------
// Multichannel phase dimmer assertion macros
// Shorthand for the clocked, reset-qualified properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PHASE_DIMMER_ASSERT_SVH
`define MULTICHANNEL_PHASE_DIMMER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mpd_pkg.sv]
// ----------------------------------------------------------------------------
// Multichannel phase dimmer package
// Shared widths, codes, reset values and interface structs.
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam int MPD_CHANNELS   = 16;
    localparam int MPD_GATE_W     = 16;
    localparam int MPD_CHAN_W     = 4;
    localparam int MPD_LEVEL_W    = 8;
    localparam int MPD_SYNC_W     = 16;
    localparam int MPD_OP_W       = 2;
    localparam int MPD_CFG_ADDR_W = 2;
    localparam int MPD_CFG_DATA_W = 16;
    localparam int MPD_IN_DATA_W  = 16;
    localparam int MPD_OUT_DATA_W = 24;

    // Division by five as a multiply by 205 and a shift by ten: exact for
    // every 8-bit value.
    localparam int MPD_DIV5_MUL   = 205;
    localparam int MPD_DIV5_SHIFT = 10;

    // Item kinds carried in tuser.
    typedef enum logic [MPD_OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_ZERO_CROSS = 2'd1,
        OP_LOAD       = 2'd2
    } t_op;

    // Configuration register indexes.
    localparam logic [MPD_CFG_ADDR_W-1:0] CFG_RESOLUTION   = 2'd0;
    localparam logic [MPD_CFG_ADDR_W-1:0] CFG_TRIM_LEVEL   = 2'd1;
    localparam logic [MPD_CFG_ADDR_W-1:0] CFG_SYNC_TIMEOUT = 2'd2;
    localparam logic [MPD_CFG_ADDR_W-1:0] CFG_DIRECT_MODE  = 2'd3;

    localparam logic [MPD_LEVEL_W-1:0] RST_RESOLUTION   = 8'd50;
    localparam logic [MPD_LEVEL_W-1:0] RST_TRIM_LEVEL   = 8'd2;
    localparam logic [MPD_SYNC_W-1:0]  RST_SYNC_TIMEOUT = 16'd2000;

    typedef struct packed {
        logic [MPD_LEVEL_W-1:0] resolution;
        logic [MPD_LEVEL_W-1:0] trim_level;
        logic [MPD_SYNC_W-1:0]  sync_timeout;
        logic                   direct_mode;
    } t_cfg;

    typedef struct packed {
        logic                  firing;
        logic                  sync_led;
        logic [MPD_GATE_W-1:0] gate_bits;
    } t_status;

endpackage

[rtl/core/mpd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Multichannel phase dimmer configuration registers
// Write-only register file decoded from a plain index/data port.
// ----------------------------------------------------------------------------
module mpd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mpd_pkg::MPD_CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mpd_pkg::MPD_CFG_DATA_W-1:0]  i_cfg_wdata,
    output mpd_pkg::t_cfg                       o_cfg
);
    import mpd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_RESOLUTION:   n_cfg.resolution   = i_cfg_wdata[MPD_LEVEL_W-1:0];
                CFG_TRIM_LEVEL:   n_cfg.trim_level   = i_cfg_wdata[MPD_LEVEL_W-1:0];
                CFG_SYNC_TIMEOUT: n_cfg.sync_timeout = i_cfg_wdata[MPD_SYNC_W-1:0];
                CFG_DIRECT_MODE:  n_cfg.direct_mode  = i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resolution   <= RST_RESOLUTION;
            r_cfg.trim_level   <= RST_TRIM_LEVEL;
            r_cfg.sync_timeout <= RST_SYNC_TIMEOUT;
            r_cfg.direct_mode  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/mpd_scale.sv]
// ----------------------------------------------------------------------------
// Multichannel phase dimmer level scaler
// Turns a raw load value into a stored level: raw, or divided by five and
// clamped to the resolution.
// ----------------------------------------------------------------------------
module mpd_scale (
    input  logic [mpd_pkg::MPD_LEVEL_W-1:0] i_value,
    input  logic [mpd_pkg::MPD_LEVEL_W-1:0] i_resolution,
    input  logic                            i_direct,
    output logic [mpd_pkg::MPD_LEVEL_W-1:0] o_level
);
    import mpd_pkg::*;

    localparam int PROD_W = 2 * MPD_LEVEL_W;

    logic [PROD_W-1:0]      w_prod;
    logic [MPD_LEVEL_W-1:0] w_quot;

    assign w_prod = PROD_W'(i_value) * PROD_W'(MPD_DIV5_MUL);
    assign w_quot = MPD_LEVEL_W'(w_prod >> MPD_DIV5_SHIFT);

    always_comb begin
        if (i_direct) begin
            o_level = i_value;
        end else if (w_quot > i_resolution) begin
            o_level = i_resolution;
        end else begin
            o_level = w_quot;
        end
    end

endmodule

[rtl/core/mpd_core.sv]
// ----------------------------------------------------------------------------
// Multichannel phase dimmer core
// Level buffers, phase counter, sync supervision and gate latches, updated
// once per item.
// ----------------------------------------------------------------------------
module mpd_core #(
    parameter int CHANNELS = mpd_pkg::MPD_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  mpd_pkg::t_op                    i_op,
    input  logic [mpd_pkg::MPD_CHAN_W-1:0]  i_channel,
    input  logic [mpd_pkg::MPD_LEVEL_W-1:0] i_level,
    input  logic                            i_last,
    input  mpd_pkg::t_cfg                   i_cfg,
    output mpd_pkg::t_status                o_status
);
    import mpd_pkg::*;

    logic [MPD_LEVEL_W-1:0] r_active [CHANNELS];
    logic [MPD_LEVEL_W-1:0] n_active [CHANNELS];
    logic [MPD_LEVEL_W-1:0] r_shadow [CHANNELS];
    logic [MPD_LEVEL_W-1:0] n_shadow [CHANNELS];
    logic                   r_pending;
    logic                   n_pending;
    logic [MPD_LEVEL_W-1:0] r_phase;
    logic [MPD_LEVEL_W-1:0] n_phase;
    logic                   r_fire;
    logic                   n_fire;
    logic [MPD_SYNC_W-1:0]  r_sync;
    logic [MPD_SYNC_W-1:0]  n_sync;
    logic [MPD_GATE_W-1:0]  r_gate;
    logic [MPD_GATE_W-1:0]  n_gate;
    logic                   r_led;
    logic                   n_led;

    always_comb begin
        n_active  = r_active;
        n_shadow  = r_shadow;
        n_pending = r_pending;
        n_phase   = r_phase;
        n_fire    = r_fire;
        n_sync    = r_sync;
        n_gate    = r_gate;
        n_led     = r_led;
        if (i_valid) begin
            unique case (i_op)
                OP_TICK: begin
                    if (r_sync >= i_cfg.sync_timeout) begin
                        n_led = 1'b0;
                    end else begin
                        n_sync = r_sync + 1'b1;
                    end
                    if (r_fire) begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            if (r_phase < r_active[i]) begin
                                n_gate[i] = 1'b1;
                            end
                        end
                        // Trim point reached: end of the firing window.
                        if (r_phase <= i_cfg.trim_level) begin
                            n_gate = '0;
                            n_fire = 1'b0;
                        end
                        n_phase = r_phase - 1'b1;
                    end
                end
                OP_ZERO_CROSS: begin
                    n_gate = '0;
                    if (r_pending) begin
                        n_active  = r_shadow;
                        n_pending = 1'b0;
                    end
                    n_phase = i_cfg.resolution;
                    n_led   = !r_led;
                    n_sync  = '0;
                    n_fire  = 1'b1;
                end
                OP_LOAD: begin
                    // A channel beyond the fitted count matches no lane.
                    for (int i = 0; i < CHANNELS; i++) begin
                        if (i_channel == MPD_CHAN_W'(i)) begin
                            n_shadow[i] = i_level;
                        end
                    end
                    if (i_last) begin
                        n_pending = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_active[i] <= '0;
                r_shadow[i] <= '0;
            end
            r_pending <= 1'b0;
            r_phase   <= '0;
            r_fire    <= 1'b0;
            r_sync    <= '0;
            r_gate    <= '0;
            r_led     <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_shadow  <= n_shadow;
            r_pending <= n_pending;
            r_phase   <= n_phase;
            r_fire    <= n_fire;
            r_sync    <= n_sync;
            r_gate    <= n_gate;
            r_led     <= n_led;
        end
    end

    assign o_status.firing    = r_fire;
    assign o_status.sync_led  = r_led;
    assign o_status.gate_bits = r_gate;

endmodule

[rtl/core/multichannel_phase_dimmer.sv]
// ----------------------------------------------------------------------------
// Multichannel phase dimmer
// Triac phase-angle dimmer for up to sixteen channels, driven by a stream of
// ticks, zero-crosses and level loads.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// s_axis    in         tvalid / tready        tuser op, tdata channel+level, tlast
// m_axis    out        tvalid / tready        tdata gate bits, sync LED, firing
// cfg       in         i_cfg_we only          index i_cfg_addr, data i_cfg_wdata
//
// Each transfer passes an input register and then the state update, whose
// registered result is presented on m_axis; one transfer is taken every cycle
// while m_axis is not stalled.
// Reset is synchronous and active low; all state and configuration is cleared
// at once, with no clearing pass.
// A stalled output holds its result; the input register takes one more
// transfer and then s_axis_tready falls, rising again in the same cycle as
// m_axis_tready.
// ----------------------------------------------------------------------------
module multichannel_phase_dimmer #(
    parameter int CHANNELS = mpd_pkg::MPD_CHANNELS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input transfers.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: channel [3:0], level_value [11:4], zero padding [15:12].
    input  logic [mpd_pkg::MPD_IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: op [1:0].
    input  logic [mpd_pkg::MPD_OP_W-1:0]        s_axis_tuser,
    input  logic                                s_axis_tlast,
    // Result transfers.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: gate_bits [15:0], sync_led [16], firing [17], zero padding [23:18].
    output logic [mpd_pkg::MPD_OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration writes.
    input  logic                                i_cfg_we,
    input  logic [mpd_pkg::MPD_CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [mpd_pkg::MPD_CFG_DATA_W-1:0]  i_cfg_wdata
);
    import mpd_pkg::*;

    localparam int PAD_W = MPD_OUT_DATA_W - MPD_GATE_W - 2;

    t_cfg                   w_cfg;
    t_status                w_status;
    logic [MPD_LEVEL_W-1:0] w_level;
    logic                   w_s_accept;
    logic                   w_advance;
    logic                   w_step;

    // Input register stage. Payload needs no reset.
    logic                   r_in_valid;
    t_op                    r_in_op;
    logic [MPD_CHAN_W-1:0]  r_in_channel;
    logic [MPD_LEVEL_W-1:0] r_in_value;
    logic                   r_in_last;

    // The result stage is the core state itself; this bit says it holds a
    // result that has not yet been transferred.
    logic                   r_out_valid;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_in_op      <= t_op'(s_axis_tuser);
            r_in_channel <= s_axis_tdata[MPD_CHAN_W-1:0];
            r_in_value   <= s_axis_tdata[MPD_CHAN_W +: MPD_LEVEL_W];
            r_in_last    <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    mpd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Scaling sits between the input register and the core update.
    mpd_scale u_scale (
        .i_value      (r_in_value),
        .i_resolution (w_cfg.resolution),
        .i_direct     (w_cfg.direct_mode),
        .o_level      (w_level)
    );

    mpd_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_step),
        .i_op      (r_in_op),
        .i_channel (r_in_channel),
        .i_level   (w_level),
        .i_last    (r_in_last),
        .i_cfg     (w_cfg),
        .o_status  (w_status)
    );

    // The core state only changes on a step, which cannot happen while a
    // result is stalled, so the state doubles as the output register.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {PAD_W'(0), w_status.firing, w_status.sync_led,
                            w_status.gate_bits};

endmodule

[rtl/core/mpd_checker.sv]
// ----------------------------------------------------------------------------
// Multichannel phase dimmer port checker
// Watches the top-level ports for ordering and consistency of results.
// ----------------------------------------------------------------------------
`include "multichannel_phase_dimmer_assert.svh"

module mpd_checker #(
    parameter int CHANNELS = mpd_pkg::MPD_CHANNELS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [mpd_pkg::MPD_OUT_DATA_W-1:0]  m_axis_tdata
);
    import mpd_pkg::*;

    // A stalled result must stay put.
    `MPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Any driven gate implies the firing window is open.
    `MPD_ASSERT_SAME(a_gate_needs_fire,
        m_axis_tvalid && (m_axis_tdata[MPD_GATE_W-1:0] != '0),
        m_axis_tdata[MPD_GATE_W + 1], "gate driven outside firing window")

    // Gates beyond the fitted channel count never drive.
    `MPD_ASSERT_SAME(a_unused_gates, m_axis_tvalid,
        (m_axis_tdata[MPD_GATE_W-1:0] >> CHANNELS) == '0,
        "gate bit set beyond channel count")

    // A new result is always traced back to an input transfer, through the input register and the core update.
    `MPD_ASSERT_SAME(a_result_origin, $rose(m_axis_tvalid),
        $past(s_axis_tvalid && s_axis_tready, 2), "result without an input transfer")

endmodule

bind multichannel_phase_dimmer mpd_checker #(.CHANNELS(CHANNELS)) u_mpd_checker (.*);
